// ===== hdl/rmm_pkg.sv =====
// Shared types, constants and codes of the running mean, median and mode core.
package rmm_pkg;

	localparam int VAL_W = 30;
	localparam int CNT_W = 16;
	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int USED_W = IDX_W + 1;
	localparam int EXP_W = 30;

	localparam logic [VAL_W-1:0] PRIME = VAL_W'(1000000007);
	localparam logic [EXP_W-1:0] FERMAT_EXP = EXP_W'(1000000005);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_SPARE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic go;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic [VAL_W-1:0] y;
	} mul_rsp_t;

endpackage

// ===== hdl/running_mean_median_mode_core.sv =====
// Top level of the running mean, median and mode core.
//
//  channel  | handshake          | fields
//  request  | start, busy        | req_type, value
//  result   | done (strobe)      | status, mean_mod, median_mod, mode_value, element_count
//
//  A request searches the table entry by entry, moves entries to open or
//  close a gap, walks the table for the median and mode, and then, unless
//  the set is empty, runs 46 modular multiplications in the shared multiplier.
//  Reset clears the fill count, total and sum; the table needs no clearing.
//  The result strobe lasts one cycle and cannot be stalled.
module running_mean_median_mode_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [29:0]          value,
	output logic                 done,
	output logic [1:0]           status,
	output logic [29:0]          mean_mod,
	output logic [29:0]          median_mod,
	output logic [29:0]          mode_value,
	output logic [15:0]          element_count
);
	import rmm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCHK, S_UPD, S_SHU, S_SHUW, S_SHD, S_SHDW,
		S_STAT, S_MRD, S_MUSE, S_MGO, S_MWT
	} state_t;

	typedef enum logic [1:0] {PH_SQ, PH_ML, PH_MEAN} phase_t;

	state_t            state_q;
	phase_t            ph_q;
	req_t              req_q;
	status_t           st_q;
	logic [VAL_W-1:0]  v_q, sum_q, acc_q, a_q, b_q, mode_v_q;
	logic [CNT_W-1:0]  total_q, cnt_hit_q, mode_c_q;
	logic [USED_W-1:0] used_q, i_q, pos_q;
	logic              found_q, got_a_q, got_b_q;
	logic [CNT_W:0]    seen_q;
	logic [$clog2(EXP_W)-1:0] k_q;

	logic              we;
	logic [IDX_W-1:0]  waddr, raddr;
	entry_t            wdata, rdata;
	mul_req_t          mreq;
	mul_rsp_t          mrsp;

	logic [VAL_W-1:0]  v_red;
	logic [CNT_W:0]    seen_n;
	logic [CNT_W-1:0]  ra, rb;
	logic [VAL_W:0]    pair_s, pair_r, pair_h;
	logic [VAL_W-1:0]  med;
	logic [VAL_W:0]    sum_add, sum_sub;

	logic              out_done_q;
	status_t           out_st_q;
	logic [VAL_W-1:0]  out_mean_q, out_med_q, out_mode_q;
	logic [CNT_W-1:0]  out_cnt_q;

	rmm_ram #(.W($bits(entry_t)), .D(DEPTH)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	rmm_modmul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	assign v_red = (value >= PRIME) ? value - PRIME : value;
	assign seen_n = seen_q + {1'b0, rdata.cnt};
	assign ra = (total_q - 1'b1) >> 1;
	assign rb = total_q >> 1;
	assign pair_s = {1'b0, a_q} + {1'b0, b_q};
	assign pair_r = (pair_s >= {1'b0, PRIME}) ? pair_s - {1'b0, PRIME} : pair_s;
	assign pair_h = pair_r[0] ? (pair_r + {1'b0, PRIME}) >> 1 : pair_r >> 1;
	assign med = total_q[0] ? a_q : pair_h[VAL_W-1:0];
	assign sum_add = {1'b0, sum_q} + {1'b0, v_q};
	assign sum_sub = {1'b0, sum_q} - {1'b0, v_q};

	always_comb begin
		we = 1'b0;
		waddr = pos_q[IDX_W-1:0];
		wdata = rdata;
		raddr = i_q[IDX_W-1:0];
		mreq.go = 1'b0;
		mreq.a = acc_q;
		mreq.b = acc_q;
		case (state_q)
			S_UPD: begin
				wdata.val = v_q;
				if (req_q == REQ_INSERT) begin
					wdata.cnt = cnt_hit_q + 1'b1;
					we = found_q && total_q < CNT_MAX;
				end else begin
					wdata.cnt = cnt_hit_q - 1'b1;
					we = (req_q == REQ_REMOVE) && found_q && cnt_hit_q > CNT_W'(1);
				end
			end
			S_SHU: begin
				raddr = IDX_W'(i_q - 1'b1);
				if (i_q == pos_q) begin
					we = 1'b1;
					wdata.val = v_q;
					wdata.cnt = CNT_W'(1);
				end
			end
			S_SHUW: begin
				we = 1'b1;
				waddr = i_q[IDX_W-1:0];
			end
			S_SHD: raddr = IDX_W'(i_q + 1'b1);
			S_SHDW: begin
				we = 1'b1;
				waddr = i_q[IDX_W-1:0];
			end
			S_MGO: begin
				mreq.go = 1'b1;
				case (ph_q)
					PH_ML: mreq.b = VAL_W'(total_q);
					PH_MEAN: mreq.a = sum_q;
					default: mreq.b = acc_q;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			total_q <= '0;
			sum_q <= '0;
			out_done_q <= 1'b0;
		end else begin
			out_done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					req_q <= req_t'(req_type);
					v_q <= v_red;
					st_q <= ST_OK;
					i_q <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (i_q < used_q && rdata.val < v_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SRD;
					end else begin
						pos_q <= i_q;
						found_q <= (i_q < used_q) && (rdata.val == v_q);
						cnt_hit_q <= rdata.cnt;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_STAT;
					if (req_q == REQ_INSERT) begin
						if (total_q >= CNT_MAX || (!found_q && used_q >= USED_W'(DEPTH))) begin
							st_q <= ST_FULL;
						end else begin
							total_q <= total_q + 1'b1;
							sum_q <= (sum_add >= {1'b0, PRIME}) ?
								VAL_W'(sum_add - {1'b0, PRIME}) : sum_add[VAL_W-1:0];
							if (!found_q) begin
								i_q <= used_q;
								state_q <= S_SHU;
							end
						end
					end else if (req_q == REQ_REMOVE) begin
						if (!found_q) begin
							st_q <= ST_ABSENT;
						end else begin
							total_q <= total_q - 1'b1;
							sum_q <= sum_sub[VAL_W] ?
								VAL_W'(sum_sub + {1'b0, PRIME}) : sum_sub[VAL_W-1:0];
							if (cnt_hit_q == CNT_W'(1)) begin
								i_q <= pos_q;
								state_q <= S_SHD;
							end
						end
					end
				end
				S_SHU: begin
					if (i_q == pos_q) begin
						used_q <= used_q + 1'b1;
						state_q <= S_STAT;
					end else begin
						state_q <= S_SHUW;
					end
				end
				S_SHUW: begin
					i_q <= i_q - 1'b1;
					state_q <= S_SHU;
				end
				S_SHD: begin
					if (i_q + 1'b1 >= used_q) begin
						used_q <= used_q - 1'b1;
						state_q <= S_STAT;
					end else begin
						state_q <= S_SHDW;
					end
				end
				S_SHDW: begin
					i_q <= i_q + 1'b1;
					state_q <= S_SHD;
				end
				S_STAT: begin
					if (total_q == '0) begin
						out_done_q <= 1'b1;
						out_st_q <= (st_q != ST_OK) ? st_q : ST_EMPTY;
						out_mean_q <= '0;
						out_med_q <= '0;
						out_mode_q <= '0;
						out_cnt_q <= '0;
						state_q <= S_IDLE;
					end else begin
						i_q <= '0;
						seen_q <= '0;
						mode_c_q <= '0;
						mode_v_q <= '0;
						got_a_q <= 1'b0;
						got_b_q <= 1'b0;
						state_q <= S_MRD;
					end
				end
				S_MRD: begin
					if (i_q < used_q) begin
						state_q <= S_MUSE;
					end else begin
						acc_q <= VAL_W'(1);
						k_q <= $bits(k_q)'(EXP_W - 1);
						ph_q <= PH_SQ;
						state_q <= S_MGO;
					end
				end
				S_MUSE: begin
					seen_q <= seen_n;
					if (!got_a_q && {1'b0, ra} < seen_n) begin
						a_q <= rdata.val;
						got_a_q <= 1'b1;
					end
					if (!got_b_q && {1'b0, rb} < seen_n) begin
						b_q <= rdata.val;
						got_b_q <= 1'b1;
					end
					if (rdata.cnt > mode_c_q) begin
						mode_c_q <= rdata.cnt;
						mode_v_q <= rdata.val;
					end
					i_q <= i_q + 1'b1;
					state_q <= S_MRD;
				end
				S_MGO: state_q <= S_MWT;
				S_MWT: if (mrsp.done) begin
					acc_q <= mrsp.y;
					state_q <= S_MGO;
					case (ph_q)
						PH_SQ: begin
							if (FERMAT_EXP[k_q]) begin
								ph_q <= PH_ML;
							end else if (k_q == '0) begin
								ph_q <= PH_MEAN;
							end else begin
								k_q <= k_q - 1'b1;
							end
						end
						PH_ML: begin
							if (k_q == '0) begin
								ph_q <= PH_MEAN;
							end else begin
								k_q <= k_q - 1'b1;
								ph_q <= PH_SQ;
							end
						end
						default: begin
							out_done_q <= 1'b1;
							out_st_q <= st_q;
							out_mean_q <= mrsp.y;
							out_med_q <= med;
							out_mode_q <= mode_v_q;
							out_cnt_q <= total_q;
							state_q <= S_IDLE;
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = out_done_q;
	assign status = out_st_q;
	assign mean_mod = out_mean_q;
	assign median_mod = out_med_q;
	assign mode_value = out_mode_q;
	assign element_count = out_cnt_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> element_count == '0)
		else $error("empty status with nonzero count");
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(DEPTH))
		else $error("distinct count out of range");
endmodule

// ===== hdl/rmm_ram.sv =====
// Generic single write port RAM with one registered read port.
module rmm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/rmm_modmul.sv =====
// Bit-serial modular multiplier, two multiplier bits per cycle.
module rmm_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  rmm_pkg::mul_req_t req,
	output rmm_pkg::mul_rsp_t rsp
);
	import rmm_pkg::*;

	localparam int STEPS = VAL_W / 2;
	localparam int CW = $clog2(STEPS + 1);

	logic [VAL_W-1:0] a_q, b_q, acc_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q, done_q;
	logic [VAL_W-1:0] mid, nxt;

	function automatic logic [VAL_W-1:0] step(input logic [VAL_W-1:0] acc,
		input logic bit_in, input logic [VAL_W-1:0] a);
		logic [VAL_W+1:0] t;
		logic [VAL_W+1:0] p1;
		logic [VAL_W+1:0] p2;
		p1 = {2'b00, PRIME};
		p2 = {1'b0, PRIME, 1'b0};
		t = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, a} : '0);
		if (t >= p2) begin
			t = t - p2;
		end else if (t >= p1) begin
			t = t - p1;
		end
		return t[VAL_W-1:0];
	endfunction

	assign mid = step(acc_q, b_q[VAL_W-1], a_q);
	assign nxt = step(mid, b_q[VAL_W-2], a_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= nxt;
			b_q <= {b_q[VAL_W-3:0], 2'b00};
		end
	end

	assign rsp.done = done_q;
	assign rsp.y = acc_q;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the running mean, median and mode core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rmm_pkg::*;

	localparam longint unsigned P_MOD = 64'd1000000007;
	localparam longint unsigned HALF_INV = 64'd500000004;
	localparam longint unsigned CYCLE_LIMIT = 64'd40000000;

	typedef struct {
		status_t st;
		logic [29:0] mean;
		logic [29:0] median;
		logic [29:0] mode;
		logic [15:0] cnt;
	} stats_t;

	logic clk, arst_n, start, busy, done;
	logic [1:0] req_type;
	logic [29:0] value;
	logic [1:0] status;
	logic [29:0] mean_mod, median_mod, mode_value;
	logic [15:0] element_count;

	logic [29:0] set_val [DEPTH];
	int unsigned set_cnt [DEPTH];
	int unsigned n_distinct, n_total;
	longint unsigned sum_acc;

	stats_t pending_stats [$];
	int unsigned errors, n_sent, n_checked, n_full, n_absent, n_empty;
	longint unsigned cycles;

	running_mean_median_mode_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
		return (a * b) % P_MOD;
	endfunction

	function automatic longint unsigned inverse(longint unsigned x);
		longint unsigned acc, b, e;
		acc = 1;
		b = x % P_MOD;
		e = P_MOD - 2;
		while (e != 0) begin
			if (e[0])
				acc = mulmod(acc, b);
			b = mulmod(b, b);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic longint unsigned value_at_rank(int unsigned r);
		int unsigned seen;
		seen = 0;
		for (int unsigned i = 0; i < n_distinct; i++) begin
			seen += set_cnt[i];
			if (r < seen)
				return set_val[i];
		end
		return 0;
	endfunction

	// update the multiset and return the statistics after the request
	function automatic stats_t update_stats(logic [1:0] rq, logic [29:0] raw);
		stats_t r;
		longint unsigned v, a, b;
		int unsigned pos, mc;
		bit found;
		status_t st;
		st = ST_OK;
		v = raw;
		if (v >= P_MOD)
			v -= P_MOD;
		pos = 0;
		while (pos < n_distinct && set_val[pos] < v)
			pos++;
		found = pos < n_distinct && set_val[pos] == v;
		if (rq == REQ_INSERT) begin
			if (n_total >= CNT_MAX || (!found && n_distinct >= DEPTH)) begin
				st = ST_FULL;
			end else begin
				if (!found) begin
					for (int unsigned i = n_distinct; i > pos; i--) begin
						set_val[i] = set_val[i-1];
						set_cnt[i] = set_cnt[i-1];
					end
					set_val[pos] = v;
					set_cnt[pos] = 0;
					n_distinct++;
				end
				set_cnt[pos]++;
				n_total++;
				sum_acc = (sum_acc + v) % P_MOD;
			end
		end else if (rq == REQ_REMOVE) begin
			if (!found) begin
				st = ST_ABSENT;
			end else begin
				set_cnt[pos]--;
				n_total--;
				sum_acc = (sum_acc + P_MOD - v) % P_MOD;
				if (set_cnt[pos] == 0) begin
					for (int unsigned i = pos; i + 1 < n_distinct; i++) begin
						set_val[i] = set_val[i+1];
						set_cnt[i] = set_cnt[i+1];
					end
					n_distinct--;
				end
			end
		end
		r.st = st;
		r.mean = '0;
		r.median = '0;
		r.mode = '0;
		r.cnt = '0;
		if (n_total == 0) begin
			if (st == ST_OK)
				r.st = ST_EMPTY;
			return r;
		end
		r.mean = 30'(mulmod(sum_acc, inverse(n_total)));
		if (n_total % 2 == 1) begin
			r.median = 30'(value_at_rank((n_total - 1) / 2));
		end else begin
			a = value_at_rank(n_total / 2 - 1);
			b = value_at_rank(n_total / 2);
			r.median = 30'(mulmod((a + b) % P_MOD, HALF_INV));
		end
		mc = 0;
		for (int unsigned i = 0; i < n_distinct; i++) begin
			if (set_cnt[i] > mc) begin
				mc = set_cnt[i];
				r.mode = set_val[i];
			end
		end
		r.cnt = 16'(n_total);
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_stats.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				stats_t e;
				e = pending_stats.pop_front();
				n_checked++;
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					errors++;
				end
				if (mean_mod !== e.mean) begin
					$error("mean_mod: expected %0d, actual %0d", e.mean, mean_mod);
					errors++;
				end
				if (median_mod !== e.median) begin
					$error("median_mod: expected %0d, actual %0d", e.median, median_mod);
					errors++;
				end
				if (mode_value !== e.mode) begin
					$error("mode_value: expected %0d, actual %0d", e.mode, mode_value);
					errors++;
				end
				if (element_count !== e.cnt) begin
					$error("element_count: expected %0d, actual %0d",
						e.cnt, element_count);
					errors++;
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(80, 10);
	endfunction

	// hold start until the transfer, then record the expected statistics
	task automatic send_request(logic [1:0] rq, logic [29:0] v, int unsigned gap);
		stats_t e;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		value <= v;
		do @(posedge clk); while (busy);
		e = update_stats(rq, v);
		if (e.st == ST_FULL)
			n_full++;
		if (e.st == ST_ABSENT)
			n_absent++;
		if (e.st == ST_EMPTY)
			n_empty++;
		pending_stats.push_back(e);
		n_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(REQ_QUERY, 30'd0, 0);
		send_request(REQ_REMOVE, 30'd5, 1);
		send_request(REQ_SPARE, 30'h3FFF_FFFF, 0);
		send_request(REQ_INSERT, 30'd0, 0);
		send_request(REQ_REMOVE, 30'd0, 2);
		send_request(REQ_INSERT, 30'd1000000006, 0);
		send_request(REQ_INSERT, 30'd1000000007, 0);
		send_request(REQ_INSERT, 30'h3FFF_FFFF, 0);
		send_request(REQ_INSERT, 30'd7, 0);
		send_request(REQ_INSERT, 30'd1000000006, 3);
		send_request(REQ_INSERT, 30'd7, 0);
		send_request(REQ_QUERY, 30'd123, 0);
		send_request(REQ_REMOVE, 30'd1000000013, 0);
		send_request(REQ_REMOVE, 30'd8, 0);
		send_request(REQ_REMOVE, 30'd1000000006, 0);
		send_request(REQ_REMOVE, 30'd0, 0);
		send_request(REQ_SPARE, 30'd0, 0);
		send_request(REQ_REMOVE, 30'd7, 5);
		send_request(REQ_REMOVE, 30'd7, 0);
		send_request(REQ_REMOVE, 30'd1000000006, 0);
		send_request(REQ_REMOVE, 30'd1000000006, 0);
		wait_drained();
	endtask

	task automatic test_full_table();
		int unsigned idx;
		for (int unsigned i = 0; i < DEPTH; i++)
			send_request(REQ_INSERT, 30'(i * 3900000 + $urandom_range(3899999)),
				(i < 32) ? pick_gap() : 0);
		send_request(REQ_INSERT, 30'd1000000006, 0);
		send_request(REQ_INSERT, set_val[$urandom_range(DEPTH - 1)], 1);
		send_request(REQ_QUERY, 30'd0, 0);
		while (n_distinct != 0) begin
			idx = $urandom_range(n_distinct - 1);
			send_request(REQ_REMOVE, set_val[idx], (n_distinct < 16) ? pick_gap() : 0);
		end
		wait_drained();
	endtask

	task automatic test_random(int unsigned n_items);
		logic [29:0] pool [16];
		logic [29:0] v;
		logic [1:0] rq;
		int unsigned r, gap, burst;
		for (int i = 0; i < 16; i++)
			pool[i] = 30'($urandom_range(1000000006));
		burst = 0;
		for (int unsigned k = 0; k < n_items; k++) begin
			if (k % 100 == 0)
				burst = $urandom_range(1) ? 40 : 0;
			r = $urandom_range(99);
			if (r < 45 && n_distinct < 48)
				rq = REQ_INSERT;
			else if (r < 85)
				rq = REQ_REMOVE;
			else if (r < 95)
				rq = REQ_QUERY;
			else
				rq = REQ_SPARE;
			r = $urandom_range(99);
			if (rq == REQ_REMOVE && n_distinct != 0 && r < 80)
				v = set_val[$urandom_range(n_distinct - 1)];
			else if (r < 70)
				v = pool[$urandom_range(15)];
			else if (r < 90)
				v = 30'($urandom);
			else
				v = 30'($urandom_range(32'h3FFF_FFFF, 1000000007));
			gap = (burst != 0) ? 0 : pick_gap();
			if (burst != 0)
				burst--;
			send_request(rq, v, gap);
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_QUERY;
		value = '0;
		cycles = 0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_full = 0;
		n_absent = 0;
		n_empty = 0;
		n_distinct = 0;
		n_total = 0;
		sum_acc = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random(500);
		repeat (100) @(posedge clk);
		if (pending_stats.size() != 0) begin
			$error("%0d results never arrived", pending_stats.size());
			errors++;
		end
		$display("Sent %0d requests, checked %0d results (%0d table full, %0d absent removes,",
			n_sent, n_checked, n_full, n_absent);
		$display("%0d empty-set results) over %0d cycles.", n_empty, cycles);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rmm_pkg.sv
hdl/rmm_ram.sv
hdl/rmm_modmul.sv
hdl/running_mean_median_mode_core.sv
tb/testbench.sv
